// File: src/tosf_pkg.sv
// Shared types and constants for the tangential obstacle steering force block.
// Holds the pipeline side-band record, stage counts and register codes.
// No dependencies.
package tosf_pkg;

    // Digit steps of each iterative unit (one result bit per stage)
    localparam int SQ1_N = 17;  // sqrt of the 33-bit squared distance
    localparam int DV1_N = 24;  // quotient bits of gain * 65536 / (d2 + 65536)
    localparam int DV2_N = 26;  // quotient bits of the rounded steering division
    localparam int SQ2_N = 24;  // sqrt of the 48-bit squared net force

    localparam logic [23:0] GAIN_RESET = 24'd256;
    localparam logic [15:0] DIST_RESET = 16'd26;

    // Register index, taken from paddr[2]
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_DIST = 1'b1;

    typedef struct packed {
        logic signed [23:0] fx;
        logic signed [23:0] fy;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic [32:0]        d2;
        logic               pos;
        logic               neg;
        logic [16:0]        d;
        logic               brake;
        logic [23:0]        m;
        logic signed [23:0] nx;
        logic signed [23:0] ny;
    } side_t;

    function automatic logic [15:0] abs17(input logic signed [16:0] v);
        logic signed [16:0] n;
        n = -v;
        return v[16] ? n[15:0] : v[15:0];
    endfunction

endpackage

// File: src/tangential_obstacle_steering_force.sv
// Top level of the tangential obstacle steering force block.
// Fully pipelined datapath with digit-per-stage square roots and dividers.
// Depends on tosf_pkg.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------------------
//  request   | start, busy (always low)       | obstacle_x/y, drone_x/y, force_x/y
//  result    | done (one-cycle strobe)        | net_x, net_y, net_magnitude, brake
//  config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// A request is taken every cycle; its done strobe rises once it has passed through
// the digit-serial stages: two square roots (17 and 24 stages) and two dividers
// (24 and 26 stages), plus ten single-register stages.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// Results cannot be held off, so nothing in the pipeline ever stalls.
module tangential_obstacle_steering_force (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] obstacle_x,
    input  logic signed [15:0] obstacle_y,
    input  logic signed [15:0] drone_x,
    input  logic signed [15:0] drone_y,
    input  logic signed [23:0] force_x,
    input  logic signed [23:0] force_y,
    output logic               done,
    output logic signed [23:0] net_x,
    output logic signed [23:0] net_y,
    output logic [23:0]        net_magnitude,
    output logic               brake,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tosf_pkg::*;

    // ---------------- configuration ----------------
    logic [23:0] gain_reg;
    logic [15:0] dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            dist_reg <= DIST_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_GAIN: gain_reg <= pwdata[23:0];
                REG_DIST: dist_reg <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_DIST) ? {16'b0, dist_reg} : {8'b0, gain_reg};
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // ---------------- stage A: relative position ----------------
    logic               a_v_reg;
    logic signed [16:0] a_rx_reg, a_ry_reg;
    logic signed [23:0] a_fx_reg, a_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        a_rx_reg <= {drone_x[15], drone_x} - {obstacle_x[15], obstacle_x};
        a_ry_reg <= {drone_y[15], drone_y} - {obstacle_y[15], obstacle_y};
        a_fx_reg <= force_x;
        a_fy_reg <= force_y;
    end

    // ---------------- stage B: squares and cross terms ----------------
    logic               b_v_reg;
    side_t              b_side_reg;
    logic [31:0]        b_ax2_reg, b_ay2_reg;
    logic signed [40:0] b_px_reg, b_py_reg;
    side_t              b_side_next;
    logic [15:0]        b_ax, b_ay;

    always_comb
    begin
        b_side_next    = '0;
        b_side_next.rx = a_rx_reg;
        b_side_next.ry = a_ry_reg;
        b_side_next.fx = a_fx_reg;
        b_side_next.fy = a_fy_reg;
        b_ax           = abs17(a_rx_reg);
        b_ay           = abs17(a_ry_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= b_side_next;
        b_ax2_reg  <= {16'b0, b_ax} * {16'b0, b_ax};
        b_ay2_reg  <= {16'b0, b_ay} * {16'b0, b_ay};
        b_px_reg   <= a_rx_reg * a_fy_reg;
        b_py_reg   <= a_ry_reg * a_fx_reg;
    end

    // ---------------- stage C + first square root: d = isqrt(d2) ----------------
    logic                 sq1_v_reg    [0:SQ1_N];
    side_t                sq1_side_reg [0:SQ1_N];
    logic [2*SQ1_N-1:0]   sq1_rad_reg  [0:SQ1_N];
    logic [SQ1_N+1:0]     sq1_rem_reg  [0:SQ1_N];
    logic [SQ1_N-1:0]     sq1_root_reg [0:SQ1_N];
    side_t                c_side_next;

    always_comb
    begin
        c_side_next     = b_side_reg;
        c_side_next.d2  = {1'b0, b_ax2_reg} + {1'b0, b_ay2_reg};
        c_side_next.pos = b_px_reg > b_py_reg;
        c_side_next.neg = b_px_reg < b_py_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq1_v_reg[0] <= 1'b0;
        else
            sq1_v_reg[0] <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        sq1_side_reg[0] <= c_side_next;
        sq1_rad_reg[0]  <= {1'b0, c_side_next.d2};
        sq1_rem_reg[0]  <= '0;
        sq1_root_reg[0] <= '0;
    end

    for (genvar k = 0; k < SQ1_N; k++)
    begin : g_sq1
        logic [SQ1_N+3:0] rem_t, trial, diff;
        logic             ge;

        always_comb
        begin
            rem_t = {sq1_rem_reg[k], sq1_rad_reg[k][2*SQ1_N-1 -: 2]};
            trial = {2'b00, sq1_root_reg[k], 2'b01};
            diff  = rem_t - trial;
            ge    = rem_t >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq1_v_reg[k+1] <= 1'b0;
            else
                sq1_v_reg[k+1] <= sq1_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq1_side_reg[k+1] <= sq1_side_reg[k];
            sq1_rad_reg[k+1]  <= {sq1_rad_reg[k][2*SQ1_N-3:0], 2'b00};
            sq1_rem_reg[k+1]  <= ge ? diff[SQ1_N+1:0] : rem_t[SQ1_N+1:0];
            sq1_root_reg[k+1] <= {sq1_root_reg[k][SQ1_N-2:0], ge};
        end
    end

    // ---------------- stage D + gain divider: m = gain*65536 / (d2+65536) ----------------
    logic           dv1_v_reg    [0:DV1_N];
    side_t          dv1_side_reg [0:DV1_N];
    logic [33:0]    dv1_rem_reg  [0:DV1_N];
    logic [23:0]    dv1_num_reg  [0:DV1_N];
    logic [33:0]    dv1_den_reg  [0:DV1_N];
    logic [DV1_N-1:0] dv1_q_reg  [0:DV1_N];
    side_t          d_side_next;

    always_comb
    begin
        d_side_next       = sq1_side_reg[SQ1_N];
        d_side_next.d     = sq1_root_reg[SQ1_N];
        d_side_next.brake = sq1_root_reg[SQ1_N] < {1'b0, dist_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv1_v_reg[0] <= 1'b0;
        else
            dv1_v_reg[0] <= sq1_v_reg[SQ1_N];
    end

    // The top 16 numerator bits are below the divisor, so start from there
    always_ff @(posedge clk)
    begin
        dv1_side_reg[0] <= d_side_next;
        dv1_rem_reg[0]  <= {18'b0, gain_reg[23:8]};
        dv1_num_reg[0]  <= {gain_reg[7:0], 16'b0};
        dv1_den_reg[0]  <= {1'b0, d_side_next.d2} + 34'd65536;
        dv1_q_reg[0]    <= '0;
    end

    for (genvar k = 0; k < DV1_N; k++)
    begin : g_dv1
        logic [34:0] rem_t, den_e, diff;
        logic        ge;

        always_comb
        begin
            rem_t = {dv1_rem_reg[k], dv1_num_reg[k][23]};
            den_e = {1'b0, dv1_den_reg[k]};
            diff  = rem_t - den_e;
            ge    = rem_t >= den_e;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv1_v_reg[k+1] <= 1'b0;
            else
                dv1_v_reg[k+1] <= dv1_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv1_side_reg[k+1] <= dv1_side_reg[k];
            dv1_rem_reg[k+1]  <= ge ? diff[33:0] : rem_t[33:0];
            dv1_num_reg[k+1]  <= {dv1_num_reg[k][22:0], 1'b0};
            dv1_den_reg[k+1]  <= dv1_den_reg[k];
            dv1_q_reg[k+1]    <= {dv1_q_reg[k][DV1_N-2:0], ge};
        end
    end

    // ---------------- stage E: |R component| * m ----------------
    logic        e_v_reg;
    side_t       e_side_reg;
    logic [39:0] e_px_reg, e_py_reg;
    side_t       e_side_next;
    logic [15:0] e_ax, e_ay;

    always_comb
    begin
        e_side_next   = dv1_side_reg[DV1_N];
        e_side_next.m = dv1_q_reg[DV1_N];
        e_ax          = abs17(e_side_next.rx);
        e_ay          = abs17(e_side_next.ry);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else
            e_v_reg <= dv1_v_reg[DV1_N];
    end

    always_ff @(posedge clk)
    begin
        e_side_reg <= e_side_next;
        e_px_reg   <= {24'b0, e_ay} * {16'b0, e_side_next.m};
        e_py_reg   <= {24'b0, e_ax} * {16'b0, e_side_next.m};
    end

    // ---------------- stage F + steering dividers: (2*num + d) / (2*d) ----------------
    logic             dv2_v_reg    [0:DV2_N];
    side_t            dv2_side_reg [0:DV2_N];
    logic [17:0]      dv2_den_reg  [0:DV2_N];
    logic [17:0]      dv2_remx_reg [0:DV2_N];
    logic [17:0]      dv2_remy_reg [0:DV2_N];
    logic [DV2_N-1:0] dv2_numx_reg [0:DV2_N];
    logic [DV2_N-1:0] dv2_numy_reg [0:DV2_N];
    logic [DV2_N-1:0] dv2_qx_reg   [0:DV2_N];
    logic [DV2_N-1:0] dv2_qy_reg   [0:DV2_N];
    logic [41:0]      f_numer_x, f_numer_y;

    always_comb
    begin
        f_numer_x = {1'b0, e_px_reg, 1'b0} + {25'b0, e_side_reg.d};
        f_numer_y = {1'b0, e_py_reg, 1'b0} + {25'b0, e_side_reg.d};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv2_v_reg[0] <= 1'b0;
        else
            dv2_v_reg[0] <= e_v_reg;
    end

    // Quotient stays below 2^26, so the top 16 bits are below the divisor
    always_ff @(posedge clk)
    begin
        dv2_side_reg[0] <= e_side_reg;
        dv2_den_reg[0]  <= {e_side_reg.d, 1'b0};
        dv2_remx_reg[0] <= {2'b00, f_numer_x[41:DV2_N]};
        dv2_remy_reg[0] <= {2'b00, f_numer_y[41:DV2_N]};
        dv2_numx_reg[0] <= f_numer_x[DV2_N-1:0];
        dv2_numy_reg[0] <= f_numer_y[DV2_N-1:0];
        dv2_qx_reg[0]   <= '0;
        dv2_qy_reg[0]   <= '0;
    end

    for (genvar k = 0; k < DV2_N; k++)
    begin : g_dv2
        logic [18:0] remx_t, remy_t, den_e, diffx, diffy;
        logic        gex, gey;

        always_comb
        begin
            den_e  = {1'b0, dv2_den_reg[k]};
            remx_t = {dv2_remx_reg[k], dv2_numx_reg[k][DV2_N-1]};
            remy_t = {dv2_remy_reg[k], dv2_numy_reg[k][DV2_N-1]};
            diffx  = remx_t - den_e;
            diffy  = remy_t - den_e;
            gex    = remx_t >= den_e;
            gey    = remy_t >= den_e;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv2_v_reg[k+1] <= 1'b0;
            else
                dv2_v_reg[k+1] <= dv2_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv2_side_reg[k+1] <= dv2_side_reg[k];
            dv2_den_reg[k+1]  <= dv2_den_reg[k];
            dv2_remx_reg[k+1] <= gex ? diffx[17:0] : remx_t[17:0];
            dv2_remy_reg[k+1] <= gey ? diffy[17:0] : remy_t[17:0];
            dv2_numx_reg[k+1] <= {dv2_numx_reg[k][DV2_N-2:0], 1'b0};
            dv2_numy_reg[k+1] <= {dv2_numy_reg[k][DV2_N-2:0], 1'b0};
            dv2_qx_reg[k+1]   <= {dv2_qx_reg[k][DV2_N-2:0], gex};
            dv2_qy_reg[k+1]   <= {dv2_qy_reg[k][DV2_N-2:0], gey};
        end
    end

    // ---------------- stage G: sign, add to drone force, saturate ----------------
    logic               g_v_reg;
    side_t              g_side_reg;
    side_t              g_side_next;
    logic signed [26:0] g_sx, g_sy;
    logic signed [27:0] g_sumx, g_sumy;
    logic               g_zero, g_negx, g_negy;

    always_comb
    begin
        g_side_next = dv2_side_reg[DV2_N];
        g_zero      = !(g_side_next.pos || g_side_next.neg) || (g_side_next.d == '0);
        // x uses -Ry, which is negative when Ry is positive
        g_negx      = (!g_side_next.ry[16] && (g_side_next.ry != '0)) ^ g_side_next.neg;
        g_negy      = g_side_next.rx[16] ^ g_side_next.neg;
        g_sx        = g_zero ? '0 :
                      (g_negx ? -$signed({1'b0, dv2_qx_reg[DV2_N]})
                              :  $signed({1'b0, dv2_qx_reg[DV2_N]}));
        g_sy        = g_zero ? '0 :
                      (g_negy ? -$signed({1'b0, dv2_qy_reg[DV2_N]})
                              :  $signed({1'b0, dv2_qy_reg[DV2_N]}));
        g_sumx      = {{4{g_side_next.fx[23]}}, g_side_next.fx} + {g_sx[26], g_sx};
        g_sumy      = {{4{g_side_next.fy[23]}}, g_side_next.fy} + {g_sy[26], g_sy};

        if (g_sumx > 28'sd8388607)
            g_side_next.nx = 24'sh7FFFFF;
        else if (g_sumx < -28'sd8388608)
            g_side_next.nx = 24'sh800000;
        else
            g_side_next.nx = g_sumx[23:0];

        if (g_sumy > 28'sd8388607)
            g_side_next.ny = 24'sh7FFFFF;
        else if (g_sumy < -28'sd8388608)
            g_side_next.ny = 24'sh800000;
        else
            g_side_next.ny = g_sumy[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_v_reg <= 1'b0;
        else
            g_v_reg <= dv2_v_reg[DV2_N];
    end

    always_ff @(posedge clk)
    begin
        g_side_reg <= g_side_next;
    end

    // ---------------- stage H: squares of the net force ----------------
    logic        h_v_reg;
    side_t       h_side_reg;
    logic [47:0] h_sqx_reg, h_sqy_reg;
    logic [23:0] h_ax, h_ay;
    logic signed [23:0] h_nnx, h_nny;

    always_comb
    begin
        h_nnx = -g_side_reg.nx;
        h_nny = -g_side_reg.ny;
        h_ax  = g_side_reg.nx[23] ? h_nnx : g_side_reg.nx;
        h_ay  = g_side_reg.ny[23] ? h_nny : g_side_reg.ny;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_v_reg <= 1'b0;
        else
            h_v_reg <= g_v_reg;
    end

    always_ff @(posedge clk)
    begin
        h_side_reg <= g_side_reg;
        h_sqx_reg  <= {24'b0, h_ax} * {24'b0, h_ax};
        h_sqy_reg  <= {24'b0, h_ay} * {24'b0, h_ay};
    end

    // ---------------- stage I + second square root: magnitude ----------------
    logic               sq2_v_reg    [0:SQ2_N];
    side_t              sq2_side_reg [0:SQ2_N];
    logic [2*SQ2_N-1:0] sq2_rad_reg  [0:SQ2_N];
    logic [SQ2_N+1:0]   sq2_rem_reg  [0:SQ2_N];
    logic [SQ2_N-1:0]   sq2_root_reg [0:SQ2_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq2_v_reg[0] <= 1'b0;
        else
            sq2_v_reg[0] <= h_v_reg;
    end

    always_ff @(posedge clk)
    begin
        sq2_side_reg[0] <= h_side_reg;
        sq2_rad_reg[0]  <= h_sqx_reg + h_sqy_reg;
        sq2_rem_reg[0]  <= '0;
        sq2_root_reg[0] <= '0;
    end

    for (genvar k = 0; k < SQ2_N; k++)
    begin : g_sq2
        logic [SQ2_N+3:0] rem_t, trial, diff;
        logic             ge;

        always_comb
        begin
            rem_t = {sq2_rem_reg[k], sq2_rad_reg[k][2*SQ2_N-1 -: 2]};
            trial = {2'b00, sq2_root_reg[k], 2'b01};
            diff  = rem_t - trial;
            ge    = rem_t >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq2_v_reg[k+1] <= 1'b0;
            else
                sq2_v_reg[k+1] <= sq2_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq2_side_reg[k+1] <= sq2_side_reg[k];
            sq2_rad_reg[k+1]  <= {sq2_rad_reg[k][2*SQ2_N-3:0], 2'b00};
            sq2_rem_reg[k+1]  <= ge ? diff[SQ2_N+1:0] : rem_t[SQ2_N+1:0];
            sq2_root_reg[k+1] <= {sq2_root_reg[k][SQ2_N-2:0], ge};
        end
    end

    // ---------------- output register ----------------
    logic               done_reg;
    logic signed [23:0] net_x_reg, net_y_reg;
    logic [23:0]        mag_reg;
    logic               brake_reg;
    side_t              o_side;

    assign o_side = sq2_side_reg[SQ2_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sq2_v_reg[SQ2_N];
    end

    // Zero the net force and magnitude on brake
    always_ff @(posedge clk)
    begin
        brake_reg <= o_side.brake;
        net_x_reg <= o_side.brake ? '0 : o_side.nx;
        net_y_reg <= o_side.brake ? '0 : o_side.ny;
        mag_reg   <= o_side.brake ? '0 : sq2_root_reg[SQ2_N];
    end

    assign done          = done_reg;
    assign net_x         = net_x_reg;
    assign net_y         = net_y_reg;
    assign net_magnitude = mag_reg;
    assign brake         = brake_reg;

endmodule

// File: tb/tangential_obstacle_steering_force_tb.sv
// Self-checking bench for the tangential obstacle steering force block.
// A scoreboard class predicts each result from the request and the register copies.
// Depends on tosf_pkg and the tangential_obstacle_steering_force RTL.
module tangential_obstacle_steering_force_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tosf_pkg::*;

    typedef struct {
        logic signed [23:0] net_x;
        logic signed [23:0] net_y;
        logic [23:0]        net_magnitude;
        logic               brake;
    } steer_result_t;

    localparam int PIPE_DRAIN = 120;
    localparam int CYCLE_LIMIT = 100000;

    class steer_scoreboard;
        steer_result_t pending[$];
        logic [23:0] gain = GAIN_RESET;
        logic [15:0] dist_thr = DIST_RESET;
        int errors = 0;

        function automatic longint unsigned int_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // round(|a| * m / d), ties away from zero, then sign of a times sgn
        function automatic longint tangent_part(longint a, longint unsigned m,
                                                longint unsigned d, int sgn);
            longint unsigned q;
            longint v;
            q = (2 * ((a < 0 ? -a : a) * m) + d) / (2 * d);
            v = (a < 0) ? -longint'(q) : longint'(q);
            return (sgn < 0) ? -v : v;
        endfunction

        function automatic longint clamp24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void note_request(logic signed [15:0] ox, logic signed [15:0] oy,
                                   logic signed [15:0] dx, logic signed [15:0] dy,
                                   logic signed [23:0] fx, logic signed [23:0] fy);
            steer_result_t e;
            longint rx, ry, cr, sx, sy, nx, ny;
            longint unsigned d2, d, m, mag;
            int sgn;
            rx = longint'(dx) - longint'(ox);
            ry = longint'(dy) - longint'(oy);
            d2 = rx * rx + ry * ry;
            d = int_root(d2);
            e.brake = 1'b0;
            if (d < dist_thr) begin
                e.net_x = '0;
                e.net_y = '0;
                e.net_magnitude = '0;
                e.brake = 1'b1;
            end
            else begin
                cr = rx * longint'(fy) - ry * longint'(fx);
                sgn = (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
                sx = 0;
                sy = 0;
                if (sgn != 0 && d != 0) begin
                    m = (longint'(gain) << 16) / (d2 + 65536);
                    sx = tangent_part(-ry, m, d, sgn);
                    sy = tangent_part(rx, m, d, sgn);
                end
                nx = clamp24(longint'(fx) + sx);
                ny = clamp24(longint'(fy) + sy);
                mag = int_root(nx * nx + ny * ny);
                if (mag > 24'hFFFFFF) mag = 24'hFFFFFF;
                e.net_x = nx[23:0];
                e.net_y = ny[23:0];
                e.net_magnitude = mag[23:0];
            end
            pending.push_back(e);
        endfunction

        function void check_result(steer_result_t got);
            steer_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result net_x=%0d net_y=%0d", $realtime,
                         got.net_x, got.net_y);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.net_x !== e.net_x) begin
                $display("%0t: net_x expected %0d actual %0d", $realtime, e.net_x, got.net_x);
                errors++;
            end
            if (got.net_y !== e.net_y) begin
                $display("%0t: net_y expected %0d actual %0d", $realtime, e.net_y, got.net_y);
                errors++;
            end
            if (got.net_magnitude !== e.net_magnitude) begin
                $display("%0t: net_magnitude expected %0d actual %0d", $realtime,
                         e.net_magnitude, got.net_magnitude);
                errors++;
            end
            if (got.brake !== e.brake) begin
                $display("%0t: brake expected %0b actual %0b", $realtime, e.brake, got.brake);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] obstacle_x = '0, obstacle_y = '0, drone_x = '0, drone_y = '0;
    logic signed [23:0] force_x = '0, force_y = '0;
    logic done;
    logic signed [23:0] net_x, net_y;
    logic [23:0] net_magnitude;
    logic brake;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    steer_scoreboard steer_sb = new();
    bit no_gaps = 1'b0;
    int cycles = 0;

    tangential_obstacle_steering_force u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .obstacle_x(obstacle_x), .obstacle_y(obstacle_y),
        .drone_x(drone_x), .drone_y(drone_y),
        .force_x(force_x), .force_y(force_y),
        .done(done), .net_x(net_x), .net_y(net_y),
        .net_magnitude(net_magnitude), .brake(brake),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        steer_result_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && done) begin
            got.net_x = net_x;
            got.net_y = net_y;
            got.net_magnitude = net_magnitude;
            got.brake = brake;
            steer_sb.check_result(got);
        end
    end

    task automatic send_request(logic signed [15:0] ox, logic signed [15:0] oy,
                                logic signed [15:0] dx, logic signed [15:0] dy,
                                logic signed [23:0] fx, logic signed [23:0] fy);
        while (!no_gaps && $urandom_range(99) < 27) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        obstacle_x <= ox;
        obstacle_y <= oy;
        drone_x <= dx;
        drone_y <= dy;
        force_x <= fx;
        force_y <= fy;
        do @(posedge clk); while (busy);
        steer_sb.note_request(ox, oy, dx, dy, fx, fy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (steer_sb.pending.size() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    // upper bits of pwdata are random to show they are dropped
    task automatic write_reg(logic idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_GAIN) steer_sb.gain = value[23:0];
        else steer_sb.dist_thr = value[15:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [23:0] g, logic [15:0] d);
        drain();
        write_reg(REG_GAIN, {8'($urandom_range(255)), g});
        write_reg(REG_DIST, {16'($urandom), d});
    endtask

    task automatic directed_requests();
        send_request(0, 0, 0, 0, 24'sd1000, -24'sd1000);
        send_request(-32768, -32768, 32767, 32767, 24'sh7FFFFF, 24'sh7FFFFF);
        send_request(32767, 32767, -32768, -32768, -24'sh800000, -24'sh800000);
        send_request(32767, -32768, -32768, 32767, 24'sh7FFFFF, -24'sh800000);
        send_request(0, 0, 256, 0, 24'sd1000, 0);
        send_request(0, 0, 256, 0, 0, 0);
        send_request(0, 0, 256, 0, 0, 24'sh7FFFFF);
        send_request(0, 0, 256, 0, 0, -24'sh800000);
        send_request(100, 100, 126, 100, 24'sd500, 24'sd500);
        send_request(100, 100, 125, 100, 24'sd500, 24'sd500);
        send_request(0, 0, 0, 26, -24'sd300, 24'sd7);
        send_request(-5, 7, 12, -3, 24'sh7FFFFF, -24'sd1);
        send_request(0, 0, 1, 1, -24'sd1, 24'sd1);
        send_request(-300, 40, 200, -900, 24'sd65536, -24'sd12);
    endtask

    task automatic random_requests(int n, bit pause_midway);
        logic signed [15:0] ox, oy, dx, dy;
        logic signed [23:0] fx, fy;
        int span;
        for (int i = 0; i < n; i++) begin
            ox = 16'($urandom);
            oy = 16'($urandom);
            case ($urandom_range(9))
                0, 1, 2: span = 40;
                3, 4, 5: span = 1500;
                default: span = 0;
            endcase
            if (span == 0) begin
                dx = 16'($urandom);
                dy = 16'($urandom);
            end
            else begin
                dx = ox + 16'($urandom_range(2 * span) - span);
                dy = oy + 16'($urandom_range(2 * span) - span);
            end
            case ($urandom_range(3))
                0: begin
                    fx = 24'($urandom_range(8191)) - 24'sd4096;
                    fy = 24'($urandom_range(8191)) - 24'sd4096;
                end
                1: begin
                    fx = $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
                    fy = 24'($urandom);
                end
                default: begin
                    fx = 24'($urandom);
                    fy = 24'($urandom);
                end
            endcase
            if ($urandom_range(19) == 0) fy = fx;
            no_gaps = (i >= n / 3 && i < n / 3 + 60);
            if (pause_midway && i == n / 2) begin
                start <= 1'b0;
                while (steer_sb.pending.size() != 0) @(posedge clk);
            end
            send_request(ox, oy, dx, dy, fx, fy);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_requests();
        random_requests(90, 1'b0);

        set_regs(24'hFFFFFF, 16'h0000);
        directed_requests();
        random_requests(80, 1'b0);

        set_regs(24'h000000, 16'hFFFF);
        random_requests(30, 1'b0);

        set_regs(24'($urandom), 16'($urandom_range(2000)));
        random_requests(150, 1'b1);

        set_regs(24'($urandom_range(65535)), 16'($urandom_range(300)));
        random_requests(70, 1'b0);

        drain();
        if (steer_sb.errors == 0 && steer_sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
